FILE: src/vstk_pkg.sv
//------------------------------------------------------------------------------
// Vector store top-k search package
// Shared constants, codes and controller/datapath handshake types.
//------------------------------------------------------------------------------
`default_nettype none

package vstk_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int MAX_DIM_DEF     = 64;
	localparam int MAX_K_DEF       = 16;

	localparam int OP_W     = 2;
	localparam int ID_W     = 64;
	localparam int COMP_W   = 16;
	localparam int STATUS_W = 2;
	localparam int SCORE_W  = 40;
	localparam int COUNT_W  = 11;
	localparam int DIM_REG_W = 7;
	localparam int K_REG_W   = 5;

	localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
	localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;
	localparam logic [OP_W-1:0] OP_SEARCH   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

	localparam logic signed [63:0] SCORE_MAX64 = 64'sd549755813887;
	localparam logic signed [63:0] SCORE_MIN64 = -64'sd549755813887;
	localparam logic [SCORE_W-1:0] SCORE_PAD   = {1'b1, {(SCORE_W-1){1'b0}}};

	localparam logic REG_DIMENSION = 1'b0;
	localparam logic REG_TOP_K     = 1'b1;

	typedef struct packed {
		logic take;
		logic start;
		logic find_step;
		logic decide;
		logic rd_last;
		logic copy_wr;
		logic id_wr;
		logic scan_issue;
		logic emit_op;
		logic emit_srch;
	} cmd_t;

	typedef struct packed {
		logic go;
		logic go_search;
		logic op_add;
		logic op_remove;
		logic find_end;
		logic match;
		logic found;
		logic full;
		logic copy_last;
		logic scan_end;
		logic pipe_idle;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: src/vstk_if.sv
//------------------------------------------------------------------------------
// Vector store top-k search channels
// Request and response channels with valid/ready handshake.
//------------------------------------------------------------------------------
`default_nettype none

interface vstk_req_if;
	logic                               valid;
	logic                               ready;
	logic [vstk_pkg::OP_W-1:0]          op;
	logic [vstk_pkg::ID_W-1:0]          entry_id;
	logic signed [vstk_pkg::COMP_W-1:0] component;

	modport source (output valid, op, entry_id, component, input ready);
	modport sink (input valid, op, entry_id, component, output ready);
endinterface

interface vstk_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [vstk_pkg::STATUS_W-1:0]       status;
	logic signed [vstk_pkg::SCORE_W-1:0] score;
	logic [vstk_pkg::ID_W-1:0]           result_id;
	logic [vstk_pkg::COUNT_W-1:0]        entry_count;
	logic                                last;

	modport source (output valid, status, score, result_id, entry_count, last, input ready);
	modport sink (input valid, status, score, result_id, entry_count, last, output ready);
endinterface

`default_nettype wire

FILE: src/vstk_ram.sv
//------------------------------------------------------------------------------
// Vector store top-k search RAM
// Simple dual-port RAM, one write port and one registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module vstk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic [AW-1:0]         raddr,
	output      logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/vstk_ctrl.sv
//------------------------------------------------------------------------------
// Vector store top-k search controller
// Sequences find, copy, scan and result phases for one request at a time.
//------------------------------------------------------------------------------
`default_nettype none

module vstk_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire vstk_pkg::sts_t  sts,
	output      vstk_pkg::cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_FIND_RD, S_FIND_CMP, S_DECIDE, S_COPY_RD, S_COPY_WR,
		S_ID_RD, S_ID_WR, S_SCAN, S_DRAIN, S_EMIT_OP, S_EMIT_SRCH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.take  = 1'b1;
				cmd.start = sts.go;
				if (sts.go) begin
					state_d = sts.go_search ? S_SCAN : S_FIND_RD;
				end
			end
			S_FIND_RD: begin
				state_d = sts.find_end ? S_DECIDE : S_FIND_CMP;
			end
			S_FIND_CMP: begin
				cmd.find_step = 1'b1;
				state_d = sts.match ? S_DECIDE : S_FIND_RD;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.op_add) begin
					state_d = (sts.found || sts.full) ? S_EMIT_OP : S_COPY_RD;
				end else if (sts.op_remove) begin
					state_d = sts.found ? S_COPY_RD : S_EMIT_OP;
				end else begin
					state_d = S_EMIT_OP;
				end
			end
			S_COPY_RD: begin
				cmd.rd_last = 1'b1;
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d = sts.copy_last ? S_ID_RD : S_COPY_RD;
			end
			S_ID_RD: begin
				cmd.rd_last = 1'b1;
				state_d = S_ID_WR;
			end
			S_ID_WR: begin
				cmd.id_wr = 1'b1;
				state_d = S_EMIT_OP;
			end
			S_SCAN: begin
				cmd.scan_issue = !sts.scan_end;
				if (sts.scan_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_idle) begin
					state_d = S_EMIT_SRCH;
				end
			end
			S_EMIT_OP: begin
				cmd.emit_op = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_EMIT_SRCH: begin
				cmd.emit_srch = sts.out_free;
				if (sts.out_free && sts.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/vstk_dp.sv
//------------------------------------------------------------------------------
// Vector store top-k search datapath
// Stores, id match, row copy, multiply-accumulate pipeline and ranked list.
//------------------------------------------------------------------------------
`default_nettype none

module vstk_dp #(
	parameter int MAX_ENTRIES = vstk_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_DIM     = vstk_pkg::MAX_DIM_DEF,
	parameter int MAX_K       = vstk_pkg::MAX_K_DEF,
	localparam int DIM_W      = $clog2(MAX_DIM + 1),
	localparam int K_W        = $clog2(MAX_K + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	vstk_req_if.sink              req,
	vstk_rsp_if.source            rsp,
	input  wire logic [DIM_W-1:0] eff_dim,
	input  wire logic [K_W-1:0]   eff_k,
	input  wire vstk_pkg::cmd_t   cmd,
	output      vstk_pkg::sts_t   sts
);
	localparam int ENT_AW    = $clog2(MAX_ENTRIES);
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int DIM_AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int VEC_DEPTH = MAX_ENTRIES * MAX_DIM;
	localparam int VEC_AW    = $clog2(VEC_DEPTH);
	localparam int KI_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int ACC_W     = 32 + DIM_AW;
	localparam int ID_W      = vstk_pkg::ID_W;
	localparam int SC_W      = vstk_pkg::SCORE_W;
	localparam int CW        = vstk_pkg::COMP_W;

	// Request latch and counters.
	logic [vstk_pkg::OP_W-1:0]     op_q;
	logic [ID_W-1:0]               id_q;
	logic [DIM_AW-1:0]             comp_cnt_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              slot_q;
	logic [DIM_AW-1:0]             idx_q;
	logic                          found_q;
	logic [vstk_pkg::STATUS_W-1:0] status_q;
	logic [KI_W-1:0]               emit_q;

	logic [DIM_AW:0] dim_x;
	logic            accept;
	logic            is_comp;
	logic            complete;
	logic [CNT_W-1:0] last_row;
	logic            idx_at_end;

	assign dim_x      = (DIM_AW+1)'(eff_dim);
	assign accept     = cmd.take && req.valid;
	assign is_comp    = (req.op == vstk_pkg::OP_ADD) || (req.op == vstk_pkg::OP_SEARCH);
	assign complete   = ({1'b0, comp_cnt_q} + (DIM_AW+1)'(1)) >= dim_x;
	assign last_row   = count_q - CNT_W'(1);
	assign idx_at_end = ({1'b0, idx_q} + (DIM_AW+1)'(1)) == dim_x;
	assign req.ready  = cmd.take;

	// Stores.
	logic [VEC_AW-1:0] vec_raddr, vec_waddr;
	logic [CW-1:0]     vec_rd, vec_wd, inc_rd;
	logic [ENT_AW-1:0] id_raddr, id_waddr;
	logic [ID_W-1:0]   id_rd, id_wd;

	function automatic logic [VEC_AW-1:0] row_addr(logic [ENT_AW-1:0] row,
	                                               logic [DIM_AW-1:0] col);
		row_addr = VEC_AW'(row) * VEC_AW'(MAX_DIM) + VEC_AW'(col);
	endfunction

	always_comb begin
		vec_raddr = row_addr(cmd.rd_last ? last_row[ENT_AW-1:0] : slot_q[ENT_AW-1:0], idx_q);
		id_raddr  = cmd.rd_last ? last_row[ENT_AW-1:0] : slot_q[ENT_AW-1:0];
		if (op_q == vstk_pkg::OP_ADD) begin
			vec_waddr = row_addr(count_q[ENT_AW-1:0], idx_q);
			vec_wd    = ({1'b0, idx_q} < dim_x) ? inc_rd : '0;
			id_waddr  = count_q[ENT_AW-1:0];
			id_wd     = id_q;
		end else begin
			vec_waddr = row_addr(slot_q[ENT_AW-1:0], idx_q);
			vec_wd    = vec_rd;
			id_waddr  = slot_q[ENT_AW-1:0];
			id_wd     = id_rd;
		end
	end

	vstk_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_inc_ram (
		.clk   (clk),
		.we    (accept && is_comp),
		.waddr (comp_cnt_q),
		.wdata (req.component),
		.raddr (idx_q),
		.rdata (inc_rd)
	);

	vstk_ram #(.WIDTH(CW), .DEPTH(VEC_DEPTH)) u_vec_ram (
		.clk   (clk),
		.we    (cmd.copy_wr),
		.waddr (vec_waddr),
		.wdata (vec_wd),
		.raddr (vec_raddr),
		.rdata (vec_rd)
	);

	vstk_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_id_ram (
		.clk   (clk),
		.we    (cmd.id_wr),
		.waddr (id_waddr),
		.wdata (id_wd),
		.raddr (id_raddr),
		.rdata (id_rd)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= vstk_pkg::OP_ADD;
			comp_cnt_q <= '0;
			count_q    <= '0;
			slot_q     <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			status_q   <= vstk_pkg::ST_OK;
			emit_q     <= '0;
		end else begin
			if (accept && is_comp) begin
				comp_cnt_q <= complete ? '0 : comp_cnt_q + DIM_AW'(1);
			end
			if (cmd.start) begin
				op_q    <= req.op;
				slot_q  <= '0;
				idx_q   <= '0;
				found_q <= 1'b0;
				emit_q  <= '0;
			end
			if (cmd.find_step) begin
				if (sts.match) begin
					found_q <= 1'b1;
				end else begin
					slot_q <= slot_q + CNT_W'(1);
				end
			end
			if (cmd.decide) begin
				if (op_q == vstk_pkg::OP_ADD) begin
					status_q <= found_q ? vstk_pkg::ST_DUP :
					            sts.full ? vstk_pkg::ST_FULL : vstk_pkg::ST_OK;
				end else begin
					status_q <= found_q ? vstk_pkg::ST_OK : vstk_pkg::ST_ABSENT;
				end
			end
			if (cmd.copy_wr) begin
				idx_q <= sts.copy_last ? '0 : idx_q + DIM_AW'(1);
			end
			if (cmd.id_wr) begin
				count_q <= (op_q == vstk_pkg::OP_ADD) ? count_q + CNT_W'(1)
				                                      : count_q - CNT_W'(1);
			end
			if (cmd.scan_issue) begin
				if (idx_at_end) begin
					idx_q  <= '0;
					slot_q <= slot_q + CNT_W'(1);
				end else begin
					idx_q <= idx_q + DIM_AW'(1);
				end
			end
			if (cmd.emit_srch) begin
				emit_q <= emit_q + KI_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			id_q <= req.entry_id;
		end
	end

	// Multiply-accumulate pipeline.
	logic                    v_s1, first_s1, last_s1;
	logic                    v_s2, first_s2, last_s2;
	logic signed [31:0]      prod_s2;
	logic [ID_W-1:0]         id_s2;
	logic signed [ACC_W-1:0] acc_q, acc_new;
	logic                    ins_v_s3;
	logic signed [SC_W-1:0]  ins_score_s3;
	logic [ID_W-1:0]         ins_id_s3;
	logic signed [63:0]      acc64;
	logic signed [SC_W-1:0]  sat_score;

	assign acc_new = (first_s2 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
	assign acc64   = 64'(acc_new);

	always_comb begin
		if (acc64 > vstk_pkg::SCORE_MAX64) begin
			sat_score = SC_W'(vstk_pkg::SCORE_MAX64);
		end else if (acc64 < vstk_pkg::SCORE_MIN64) begin
			sat_score = SC_W'(vstk_pkg::SCORE_MIN64);
		end else begin
			sat_score = acc64[SC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ins_v_s3 <= 1'b0;
		end else begin
			v_s1     <= cmd.scan_issue;
			v_s2     <= v_s1;
			ins_v_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (idx_q == '0);
		last_s1  <= idx_at_end;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= $signed(vec_rd) * $signed(inc_rd);
		id_s2    <= id_rd;
		if (v_s2) begin
			acc_q <= acc_new;
		end
		ins_score_s3 <= sat_score;
		ins_id_s3    <= id_s2;
	end

	// Ranked list: each position keeps, takes the new entry, or shifts down.
	logic signed [SC_W-1:0] best_score_q [MAX_K];
	logic [ID_W-1:0]        best_id_q [MAX_K];
	logic [K_W-1:0]         filled_q;
	logic [MAX_K-1:0]       ge;

	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			ge[j] = ((KI_W+1)'(j) < (KI_W+1)'(filled_q)) && (best_score_q[j] >= ins_score_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (ins_v_s3) begin
			for (int j = 0; j < MAX_K; j++) begin
				if (!ge[j]) begin
					if (j == 0 || ge[(j > 0) ? j - 1 : 0]) begin
						best_score_q[j] <= ins_score_s3;
						best_id_q[j]    <= ins_id_s3;
					end else begin
						best_score_q[j] <= best_score_q[(j > 0) ? j - 1 : 0];
						best_id_q[j]    <= best_id_q[(j > 0) ? j - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (cmd.start) begin
			filled_q <= '0;
		end else if (ins_v_s3 && (filled_q < eff_k)) begin
			filled_q <= filled_q + K_W'(1);
		end
	end

	// Response register.
	logic emit_fill;
	assign emit_fill = (KI_W+1)'(emit_q) < (KI_W+1)'(filled_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (cmd.emit_op || cmd.emit_srch) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_op) begin
			rsp.status    <= status_q;
			rsp.score     <= '0;
			rsp.result_id <= '0;
			rsp.last      <= 1'b1;
		end else if (cmd.emit_srch) begin
			rsp.status    <= vstk_pkg::ST_OK;
			rsp.score     <= emit_fill ? best_score_q[emit_q] : vstk_pkg::SCORE_PAD;
			rsp.result_id <= emit_fill ? best_id_q[emit_q] : '1;
			rsp.last      <= sts.emit_last;
		end
		if (cmd.emit_op || cmd.emit_srch) begin
			rsp.entry_count <= vstk_pkg::COUNT_W'(count_q);
		end
	end

	// Status to the controller.
	always_comb begin
		sts.go        = req.valid && (!is_comp || complete);
		sts.go_search = req.op == vstk_pkg::OP_SEARCH;
		sts.op_add    = op_q == vstk_pkg::OP_ADD;
		sts.op_remove = op_q == vstk_pkg::OP_REMOVE;
		sts.find_end  = slot_q == count_q;
		sts.match     = id_rd == id_q;
		sts.found     = found_q;
		sts.full      = count_q == CNT_W'(MAX_ENTRIES);
		sts.copy_last = idx_q == DIM_AW'(MAX_DIM - 1);
		sts.scan_end  = slot_q == count_q;
		sts.pipe_idle = !v_s1 && !v_s2 && !ins_v_s3;
		sts.out_free  = !rsp.valid || rsp.ready;
		sts.emit_last = ((KI_W+1)'(emit_q) + (KI_W+1)'(1)) == (KI_W+1)'(eff_k);
	end

	// Checks.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_filled_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_srch |-> (filled_q <= eff_k))
		else $error("ranked list longer than top_k");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_op || cmd.emit_srch) |-> (!rsp.valid || rsp.ready))
		else $error("result overwrites one not yet taken");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> (slot_q < count_q))
		else $error("scan beyond stored entries");

	a_insert_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_srch |-> (!v_s1 && !v_s2 && !ins_v_s3))
		else $error("search result emitted before scan drained");

endmodule

`default_nettype wire

FILE: src/vector_store_top_k_dot_search.sv
//------------------------------------------------------------------------------
// Vector store with brute-force top-k dot-product search
// Top level: configuration registers, controller and datapath.
//------------------------------------------------------------------------------
// The block keeps up to MAX_ENTRIES vectors of MAX_DIM signed Q1.15
// components, each tagged with a 64-bit id, and serves one request at a time.
// Add and search requests each carry one component; the request that brings
// component number dimension-1 completes the vector and starts the work.
// Remove and contains act at once on their id. A request that does not
// complete a vector is taken whenever the block is idle. Id lookups step
// through the id store with a read state and a compare state per slot, and a
// successful add or remove adds a copy of MAX_DIM row components and the id.
// A search runs one multiply-accumulate per cycle through a single port of
// the vector memory, followed by top_k results, each sent once the consumer
// has taken the one before. Scores are saturated Q10.30 values; padding
// results carry the most negative score and the all-ones id. Configuration
// (dimension at byte 0, top_k at byte 4) must be written only while the
// block is idle. The stores need no clearing pass after reset.
//------------------------------------------------------------------------------
`default_nettype none

module vector_store_top_k_dot_search #(
	parameter int MAX_ENTRIES = vstk_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_DIM     = vstk_pkg::MAX_DIM_DEF,
	parameter int MAX_K       = vstk_pkg::MAX_K_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	vstk_req_if.sink         req,
	vstk_rsp_if.source       rsp
);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int K_W   = $clog2(MAX_K + 1);

	logic [vstk_pkg::DIM_REG_W-1:0] dimension_q;
	logic [vstk_pkg::K_REG_W-1:0]   top_k_q;
	logic [DIM_W-1:0]               eff_dim;
	logic [K_W-1:0]                 eff_k;
	vstk_pkg::cmd_t                 cmd;
	vstk_pkg::sts_t                 sts;

	assign pready = 1'b1;

	// Register write happens in the access phase of an APB request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= vstk_pkg::DIM_REG_W'(64);
			top_k_q     <= vstk_pkg::K_REG_W'(1);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == vstk_pkg::REG_TOP_K) begin
				top_k_q <= pwdata[vstk_pkg::K_REG_W-1:0];
			end else begin
				dimension_q <= pwdata[vstk_pkg::DIM_REG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == vstk_pkg::REG_TOP_K) ? 32'(top_k_q) : 32'(dimension_q);

	// Zero acts as one and anything beyond the build limit is clamped to it.
	always_comb begin
		if (dimension_q == '0) begin
			eff_dim = DIM_W'(1);
		end else if (32'(dimension_q) > MAX_DIM) begin
			eff_dim = DIM_W'(MAX_DIM);
		end else begin
			eff_dim = DIM_W'(dimension_q);
		end
		if (top_k_q == '0) begin
			eff_k = K_W'(1);
		end else if (32'(top_k_q) > MAX_K) begin
			eff_k = K_W'(MAX_K);
		end else begin
			eff_k = K_W'(top_k_q);
		end
	end

	vstk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	vstk_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_DIM     (MAX_DIM),
		.MAX_K       (MAX_K)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.eff_dim (eff_dim),
		.eff_k   (eff_k),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

`default_nettype wire

FILE: sim/testbench.sv
//------------------------------------------------------------------------------
// Vector store top-k search testbench
// Drives add, remove, contains and search requests with random pacing on both
// channels, keeps an independent model of the table and checks every response.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [vstk_pkg::OP_W-1:0]          op;
		logic [vstk_pkg::ID_W-1:0]          id;
		logic signed [vstk_pkg::COMP_W-1:0] comp;
	} request_t;

	typedef struct {
		logic [vstk_pkg::STATUS_W-1:0] status;
		logic [vstk_pkg::SCORE_W-1:0]  score;
		logic [vstk_pkg::ID_W-1:0]     id;
		logic [vstk_pkg::COUNT_W-1:0]  count;
		logic                          last;
	} response_t;

	localparam int ROWS      = vstk_pkg::MAX_ENTRIES_DEF;
	localparam int COLS      = vstk_pkg::MAX_DIM_DEF;
	localparam int KMAX      = vstk_pkg::MAX_K_DEF;
	localparam int IDLE_MAX  = 20000;
	localparam int HOLD_LEN  = 400;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	vstk_req_if req ();
	vstk_rsp_if rsp ();

	vector_store_top_k_dot_search u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req), .rsp(rsp)
	);

	// Pending requests for the driver and responses the table model predicts.
	request_t  pending_reqs[$];
	response_t expected_rsps[$];
	int        err_cnt = 0;

	// Table model state and its copy of the two registers.
	logic signed [vstk_pkg::COMP_W-1:0] row_vec [0:ROWS-1][0:COLS-1];
	logic [vstk_pkg::ID_W-1:0]          row_id [0:ROWS-1];
	int                                 row_cnt = 0;
	logic signed [vstk_pkg::COMP_W-1:0] query_buf [0:COLS-1];
	int                                 buf_pos = 0;
	int                                 dim_reg = 64;
	int                                 k_reg = 1;
	logic [vstk_pkg::ID_W-1:0]          id_pool [0:15];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	//--------------------------------------------------------------------------
	// Table model. Registers out of range are clamped the way the block does.
	//--------------------------------------------------------------------------
	function automatic int eff_dim();
		if (dim_reg == 0) return 1;
		if (dim_reg > COLS) return COLS;
		return dim_reg;
	endfunction

	function automatic int eff_k();
		if (k_reg == 0) return 1;
		if (k_reg > KMAX) return KMAX;
		return k_reg;
	endfunction

	function automatic int find_row(logic [vstk_pkg::ID_W-1:0] id);
		for (int s = 0; s < row_cnt; s++)
			if (row_id[s] == id) return s;
		return -1;
	endfunction

	function automatic void push_rsp(logic [vstk_pkg::STATUS_W-1:0] st,
			logic [vstk_pkg::SCORE_W-1:0] sc, logic [vstk_pkg::ID_W-1:0] id, logic last);
		response_t r;
		r.status = st;
		r.score = sc;
		r.id = id;
		r.count = vstk_pkg::COUNT_W'(row_cnt);
		r.last = last;
		expected_rsps.insert(expected_rsps.size(), r);
	endfunction

	// Scores every stored row against the query and keeps the k best. A later
	// row only displaces an earlier one when its score is strictly higher.
	function automatic void rank_rows(int d);
		logic signed [63:0]        best_sc [0:KMAX-1];
		logic [vstk_pkg::ID_W-1:0] best_id [0:KMAX-1];
		logic signed [63:0]        acc;
		int k, filled, p, j;
		k = eff_k();
		filled = 0;
		for (int s = 0; s < row_cnt; s++) begin
			acc = 0;
			for (int i = 0; i < d; i++)
				acc += 64'(row_vec[s][i]) * 64'(query_buf[i]);
			if (acc > vstk_pkg::SCORE_MAX64) acc = vstk_pkg::SCORE_MAX64;
			if (acc < vstk_pkg::SCORE_MIN64) acc = vstk_pkg::SCORE_MIN64;
			p = 0;
			while (p < filled && !(acc > best_sc[p])) p++;
			if (p >= k) continue;
			j = (filled < k) ? filled : k - 1;
			for (; j > p; j--) begin
				best_sc[j] = best_sc[j-1];
				best_id[j] = best_id[j-1];
			end
			best_sc[p] = acc;
			best_id[p] = row_id[s];
			if (filled < k) filled++;
		end
		for (int r = 0; r < k; r++) begin
			if (r < filled)
				push_rsp(vstk_pkg::ST_OK, best_sc[r][vstk_pkg::SCORE_W-1:0], best_id[r],
					r + 1 == k);
			else
				push_rsp(vstk_pkg::ST_OK, vstk_pkg::SCORE_PAD, '1, r + 1 == k);
		end
	endfunction

	function automatic void model_request(request_t q);
		int slot, d;
		if (q.op == vstk_pkg::OP_REMOVE) begin
			slot = find_row(q.id);
			if (slot < 0) begin
				push_rsp(vstk_pkg::ST_ABSENT, '0, '0, 1'b1);
				return;
			end
			// The last row moves into the freed slot.
			if (slot != row_cnt - 1) begin
				for (int i = 0; i < COLS; i++) row_vec[slot][i] = row_vec[row_cnt-1][i];
				row_id[slot] = row_id[row_cnt-1];
			end
			row_cnt--;
			push_rsp(vstk_pkg::ST_OK, '0, '0, 1'b1);
			return;
		end
		if (q.op == vstk_pkg::OP_CONTAINS) begin
			push_rsp(find_row(q.id) >= 0 ? vstk_pkg::ST_OK : vstk_pkg::ST_ABSENT,
				'0, '0, 1'b1);
			return;
		end
		// Add and search components share the buffer; the op of the
		// completing component decides what the vector is used for.
		d = eff_dim();
		if (buf_pos >= COLS) buf_pos = 0;
		query_buf[buf_pos] = q.comp;
		if (buf_pos + 1 < d) begin
			buf_pos++;
			return;
		end
		buf_pos = 0;
		if (q.op == vstk_pkg::OP_SEARCH) begin
			rank_rows(d);
		end else if (find_row(q.id) >= 0) begin
			push_rsp(vstk_pkg::ST_DUP, '0, '0, 1'b1);
		end else if (row_cnt >= ROWS) begin
			push_rsp(vstk_pkg::ST_FULL, '0, '0, 1'b1);
		end else begin
			for (int i = 0; i < COLS; i++) row_vec[row_cnt][i] = (i < d) ? query_buf[i] : '0;
			row_id[row_cnt] = q.id;
			row_cnt++;
			push_rsp(vstk_pkg::ST_OK, '0, '0, 1'b1);
		end
	endfunction

	//--------------------------------------------------------------------------
	// Request driver: bursts of random length separated by random gaps.
	//--------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		request_t q;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				req.valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end else begin
				q = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.op <= q.op;
				req.entry_id <= q.id;
				req.component <= q.comp;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
	end

	//--------------------------------------------------------------------------
	// Response sink: stalls follow one of three patterns, redrawn at random. After
	// the tenth response it holds off for a long stretch while requests keep coming.
	//--------------------------------------------------------------------------
	int rsp_seen = 0;
	int hold_left = 0;
	int pat_cycle = 0;
	int pat_mode = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_seen++;
				if (rsp_seen == 10) hold_left = HOLD_LEN;
			end
			pat_cycle++;
			if (pat_cycle % 64 == 0) pat_mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else case (pat_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 1) == 1);
				default: rsp.ready <= (pat_cycle % 5 != 2);
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Monitor: models each accepted request and checks each accepted response.
	//--------------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		request_t  q;
		response_t e;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				q.op = req.op;
				q.id = req.entry_id;
				q.comp = req.component;
				model_request(q);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response: status %0d id %h", rsp.status, rsp.result_id);
					err_cnt++;
				end else begin
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						err_cnt++;
					end
					if (rsp.score !== e.score) begin
						$error("score: expected %h, got %h", e.score, rsp.score);
						err_cnt++;
					end
					if (rsp.result_id !== e.id) begin
						$error("result_id: expected %h, got %h", e.id, rsp.result_id);
						err_cnt++;
					end
					if (rsp.entry_count !== e.count) begin
						$error("entry_count: expected %0d, got %0d", e.count, rsp.entry_count);
						err_cnt++;
					end
					if (rsp.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, rsp.last);
						err_cnt++;
					end
				end
			end
			// Watchdog on cycles without any handshake.
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_MAX) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Stimulus helpers.
	//--------------------------------------------------------------------------
	task automatic queue_req(logic [vstk_pkg::OP_W-1:0] op, logic [vstk_pkg::ID_W-1:0] id,
			logic [vstk_pkg::COMP_W-1:0] comp);
		request_t q;
		q.op = op;
		q.id = id;
		q.comp = comp;
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	// Queues a whole vector of random components for the current dimension.
	task automatic queue_vector(logic [vstk_pkg::OP_W-1:0] op, logic [vstk_pkg::ID_W-1:0] id);
		for (int i = 0; i < eff_dim(); i++)
			queue_req(op, id, vstk_pkg::COMP_W'($urandom));
	endtask

	// Waits until nothing is pending or outstanding, then lets the block
	// finish any component it is still absorbing.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle. Only called while idle.
	task automatic write_reg(logic reg_sel, int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= (reg_sel == vstk_pkg::REG_TOP_K) ? 3'd4 : 3'd0;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == vstk_pkg::REG_TOP_K) k_reg = value & 32'h1f;
		else dim_reg = value & 32'h7f;
	endtask

	task automatic set_regs(int dim, int k);
		wait_drained();
		write_reg(vstk_pkg::REG_DIMENSION, dim);
		write_reg(vstk_pkg::REG_TOP_K, k);
	endtask

	//--------------------------------------------------------------------------
	// Test sequence.
	//--------------------------------------------------------------------------
	initial begin
		int op_pick;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < 16; i++) id_pool[i] = {$urandom, $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with two-component vectors and four results.
		set_regs(2, 4);
		queue_req(vstk_pkg::OP_CONTAINS, 64'd7, '0);       // absent on an empty table
		queue_req(vstk_pkg::OP_REMOVE, 64'd7, '0);
		queue_req(vstk_pkg::OP_SEARCH, '0, 16'sh4000);    // empty table gives padding only
		queue_req(vstk_pkg::OP_SEARCH, '0, 16'sh4000);
		queue_req(vstk_pkg::OP_ADD, '0, 16'sh7fff);
		queue_req(vstk_pkg::OP_ADD, '0, 16'sh8000);
		queue_req(vstk_pkg::OP_ADD, '1, 16'sh8000);
		queue_req(vstk_pkg::OP_ADD, '1, 16'sh8000);
		queue_req(vstk_pkg::OP_ADD, 64'd5, 16'sh8000);    // same vector: ties by slot
		queue_req(vstk_pkg::OP_ADD, 64'd5, 16'sh8000);
		queue_req(vstk_pkg::OP_ADD, '0, 16'sh0001);       // duplicate id
		queue_req(vstk_pkg::OP_ADD, '0, 16'sh0001);
		queue_req(vstk_pkg::OP_SEARCH, '0, 16'sh8000);
		queue_req(vstk_pkg::OP_SEARCH, '0, 16'sh8000);
		queue_req(vstk_pkg::OP_CONTAINS, '1, '0);
		queue_req(vstk_pkg::OP_REMOVE, '0, '0);           // first row, last one moves in
		queue_req(vstk_pkg::OP_ADD, 64'd9, 16'sh1234);    // add component, then a search
		queue_req(vstk_pkg::OP_SEARCH, 64'd9, 16'sh7fff); // component completes as search
		queue_req(vstk_pkg::OP_CONTAINS, 64'd9, '0);

		// Dimension lowered while a vector is half delivered: the next
		// component completes it. Dimension 0 acts as 1, top_k 0 as 1.
		set_regs(3, 31);
		queue_req(vstk_pkg::OP_ADD, 64'd11, 16'sh0100);
		queue_req(vstk_pkg::OP_ADD, 64'd11, 16'sh0200);
		set_regs(0, 0);
		queue_req(vstk_pkg::OP_ADD, 64'd11, 16'sh0300);
		queue_req(vstk_pkg::OP_SEARCH, '0, 16'sh7fff);

		// Both registers above their limits: the widest query and the full
		// result list, padded past the stored rows.
		set_regs(127, 31);
		queue_vector(vstk_pkg::OP_SEARCH, '0);

		// Random part: mostly well-formed requests over a small pool of ids.
		for (int ph = 0; ph < 2; ph++) begin
			set_regs($urandom_range(1, 3), $urandom_range(1, 16));
			for (int n = 0; n < 5; n++) begin
				op_pick = $urandom_range(0, 9);
				if (op_pick < 4)
					queue_vector(vstk_pkg::OP_ADD, id_pool[$urandom_range(0, 15)]);
				else if (op_pick < 6)
					queue_vector(vstk_pkg::OP_SEARCH, {$urandom, $urandom});
				else if (op_pick == 6)
					queue_req(vstk_pkg::OP_REMOVE, id_pool[$urandom_range(0, 15)], '0);
				else if (op_pick == 7)
					queue_req(vstk_pkg::OP_CONTAINS, id_pool[$urandom_range(0, 15)], '0);
				else
					queue_req(vstk_pkg::OP_W'($urandom_range(0, 3)), {$urandom, $urandom},
						vstk_pkg::COMP_W'($urandom));
			end
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (err_cnt == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
src/vstk_pkg.sv
src/vstk_if.sv
src/vstk_ram.sv
src/vstk_ctrl.sv
src/vstk_dp.sv
src/vector_store_top_k_dot_search.sv
sim/testbench.sv
